[rtl/core/tet_pkg.sv]
// ----------------------------------------------------------------------------
// Token expiry table package
// Shared types, codes and width constants for the token expiry table.
// ----------------------------------------------------------------------------
`default_nettype none

package tet_pkg;

    // Fixed field widths of the request and result transactions.
    localparam int ACTION_W     = 2;
    localparam int TOKEN_KEY_W  = 40;
    localparam int TIME_W       = 31;
    localparam int TTL_W        = 31;
    localparam int EXPIRY_W     = 32;
    localparam int COUNT_OUT_W  = 7;
    localparam int STATUS_W     = 2;
    localparam int KEY_WIDE_W   = 64;

    localparam int          ENTRIES_DEFAULT  = 64;
    localparam int          KEY_BITS_DEFAULT = 40;
    localparam logic [TTL_W-1:0] TTL_RESET   = TTL_W'(5);

    // Largest count that fits the result field.
    localparam int COUNT_SAT = (1 << COUNT_OUT_W) - 1;

    // Request actions.
    localparam logic [ACTION_W-1:0] ACT_GENERATE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RENEW    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COUNT    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP      = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STS_ABSENT   = 2'd1;
    localparam logic [STATUS_W-1:0] STS_REMOVED  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_FULL     = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DECIDE
    } tet_state_t;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

    // Status flags from the scan unit back to the sequencer.
    typedef struct packed {
        logic match_hit;
        logic free_hit;
    } scan_flags_t;

endpackage

`default_nettype wire

[rtl/core/tet_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tet_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/tet_scan.sv]
// ----------------------------------------------------------------------------
// Token expiry table scan unit
// Looks at one table entry per cycle while sample is set and keeps the first
// key match, the first reusable slot and the number of unexpired entries.
// ----------------------------------------------------------------------------
`default_nettype none

module tet_scan #(
    parameter  int ENTRIES  = tet_pkg::ENTRIES_DEFAULT,
    parameter  int KEY_BITS = tet_pkg::KEY_BITS_DEFAULT,
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W    = $clog2(ENTRIES + 1)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire tet_pkg::scan_ctl_t              ctl,
    input  wire logic                            rd_used,
    input  wire logic [tet_pkg::EXPIRY_W-1:0]    rd_expiry,
    input  wire logic [KEY_BITS-1:0]             rd_key,
    input  wire logic [IDX_W-1:0]                rd_idx,
    input  wire logic [KEY_BITS-1:0]             key,
    input  wire logic [tet_pkg::TIME_W-1:0]      now,
    output tet_pkg::scan_flags_t                 flags,
    output logic      [IDX_W-1:0]                match_idx,
    output logic      [tet_pkg::EXPIRY_W-1:0]    match_expiry,
    output logic      [IDX_W-1:0]                free_idx,
    output logic      [CNT_W-1:0]                count
);

    import tet_pkg::*;

    scan_flags_t          flags_reg, flags_next;
    logic [IDX_W-1:0]     match_idx_reg, match_idx_next;
    logic [EXPIRY_W-1:0]  match_exp_reg, match_exp_next;
    logic [IDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 live;

    always_comb
    begin
        flags_next     = flags_reg;
        match_idx_next = match_idx_reg;
        match_exp_next = match_exp_reg;
        free_idx_next  = free_idx_reg;
        count_next     = count_reg;
        live           = rd_used && (rd_expiry > {1'b0, now});
        if (ctl.clear)
        begin
            flags_next = '0;
            count_next = '0;
        end
        else if (ctl.sample)
        begin
            if (rd_used && (rd_key == key) && !flags_reg.match_hit)
            begin
                flags_next.match_hit = 1'b1;
                match_idx_next       = rd_idx;
                match_exp_next       = rd_expiry;
            end
            // An empty entry or one that has run out may be taken over.
            if (!live && !flags_reg.free_hit)
            begin
                flags_next.free_hit = 1'b1;
                free_idx_next       = rd_idx;
            end
            if (live)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg <= match_idx_next;
        match_exp_reg <= match_exp_next;
        free_idx_reg  <= free_idx_next;
    end

    assign flags        = flags_reg;
    assign match_idx    = match_idx_reg;
    assign match_expiry = match_exp_reg;
    assign free_idx     = free_idx_reg;
    assign count        = count_reg;

endmodule

`default_nettype wire

[rtl/core/token_expiry_table_top.sv]
// ----------------------------------------------------------------------------
// Token expiry table
// Fixed-capacity table of token keys with expiry times, held in one RAM.
// ----------------------------------------------------------------------------
// Every request walks the whole table while the single RAM read port reads
// one entry per cycle in ST_SCAN; ST_LAST takes in the last read data, and
// ST_DECIDE writes any chosen entry back and loads the result register, but
// holds off while the result register is full and out_stall is high. The
// block then returns to ST_IDLE, in which it can take the next request. A new
// request is taken only once the previous one has been decided, but the
// result register lets the next request start while an older result still
// waits on out_stall. After reset the block clears the table, one entry per
// cycle, and keeps in_stall high meanwhile; ttl writes are taken at any time,
// with cfg_ready always high, and must only come while the block is idle.
// Generate stores now + ttl for the key, overwriting a matching entry or else
// the lowest-numbered empty or expired slot; when neither exists the request
// is dropped with status 3. Renew refreshes an unexpired entry, removes an
// expired one (status 2) or reports an absent key (status 1). Count returns
// the number of entries whose expiry is after current_time, saturating at 127.
// ----------------------------------------------------------------------------
`default_nettype none

module token_expiry_table_top #(
    parameter int ENTRIES  = tet_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS = tet_pkg::KEY_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Request channel.
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [tet_pkg::ACTION_W-1:0]       action,
    input  wire logic [tet_pkg::TOKEN_KEY_W-1:0]    token_key,
    input  wire logic [tet_pkg::TIME_W-1:0]         current_time,
    // Result channel.
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [tet_pkg::COUNT_OUT_W-1:0]    unexpired_count,
    output logic      [tet_pkg::STATUS_W-1:0]       status,
    // ttl register write channel.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tet_pkg::TTL_W-1:0]          cfg_data
);

    import tet_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int MEM_W = 1 + EXPIRY_W + KEY_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    tet_state_t            state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  samp_reg;
    logic [IDX_W-1:0]      samp_idx_reg;
    logic [TTL_W-1:0]      ttl_reg;

    // Captured request.
    logic [ACTION_W-1:0]   act_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [KEY_WIDE_W-1:0] key_wide;

    // Result register.
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_OUT_W-1:0] count_out_reg, count_out_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    // RAM ports.
    logic                  mem_we, mem_re;
    logic [IDX_W-1:0]      mem_waddr;
    logic [MEM_W-1:0]      mem_wdata, mem_rdata;

    // Scan unit.
    scan_ctl_t             scan_ctl;
    scan_flags_t           scan_flags;
    logic [IDX_W-1:0]      match_idx, free_idx;
    logic [EXPIRY_W-1:0]   match_expiry;
    logic [CNT_W-1:0]      scan_cnt;

    logic                  in_take, out_take, out_free, out_load;
    logic [EXPIRY_W-1:0]   new_expiry;

    assign key_wide   = KEY_WIDE_W'(token_key);
    assign in_take    = in_valid && !in_stall;
    assign out_take   = out_valid_reg && !out_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    // Both terms are 31 bits, so the 32-bit sum never needs to saturate.
    assign new_expiry = {1'b0, now_reg} + {1'b0, ttl_reg};
    assign cfg_ready  = 1'b1;

    tet_ram #(
        .WIDTH (MEM_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    tet_scan #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (scan_ctl),
        .rd_used      (mem_rdata[MEM_W-1]),
        .rd_expiry    (mem_rdata[MEM_W-2 -: EXPIRY_W]),
        .rd_key       (mem_rdata[KEY_BITS-1:0]),
        .rd_idx       (samp_idx_reg),
        .key          (key_reg),
        .now          (now_reg),
        .flags        (scan_flags),
        .match_idx    (match_idx),
        .match_expiry (match_expiry),
        .free_idx     (free_idx),
        .count        (scan_cnt)
    );

    // Sequencer: next state, RAM controls and the result computation.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        in_stall       = 1'b1;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '0;
        scan_ctl       = '0;
        out_load       = 1'b0;
        count_out_next = count_out_reg;
        status_next    = status_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // Reset pass: one entry marked empty per cycle.
                mem_we = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                in_stall       = 1'b0;
                scan_ctl.clear = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                mem_re          = 1'b1;
                scan_ctl.sample = samp_reg;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_LAST;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_LAST:
            begin
                scan_ctl.sample = samp_reg;
                state_next      = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                count_out_next = '0;
                status_next    = STS_DONE;
                case (act_reg)
                    ACT_GENERATE:
                    begin
                        mem_wdata = {1'b1, new_expiry, key_reg};
                        if (scan_flags.match_hit)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = match_idx;
                        end
                        else if (scan_flags.free_hit)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = free_idx;
                        end
                        else
                        begin
                            status_next = STS_FULL;
                        end
                    end
                    ACT_RENEW:
                    begin
                        mem_waddr = match_idx;
                        if (!scan_flags.match_hit)
                        begin
                            status_next = STS_ABSENT;
                        end
                        else if (match_expiry > {1'b0, now_reg})
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {1'b1, new_expiry, key_reg};
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = {1'b0, match_expiry, key_reg};
                            status_next = STS_REMOVED;
                        end
                    end
                    ACT_COUNT:
                    begin
                        if (32'(scan_cnt) > 32'(COUNT_SAT))
                        begin
                            count_out_next = COUNT_OUT_W'(COUNT_SAT);
                        end
                        else
                        begin
                            count_out_next = COUNT_OUT_W'(scan_cnt);
                        end
                    end
                    ACT_NOP:
                    begin
                        status_next = STS_DONE;
                    end
                    default:
                    begin
                        status_next = STS_DONE;
                    end
                endcase
                // Hold the decision until the result register can take it.
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_we         = 1'b0;
                    count_out_next = count_out_reg;
                    status_next    = status_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                idx_next   = '0;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            samp_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            ttl_reg       <= TTL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            samp_reg      <= (state_reg == ST_SCAN);
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                ttl_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        samp_idx_reg  <= idx_reg;
        count_out_reg <= count_out_next;
        status_reg    <= status_next;
        if (in_take)
        begin
            act_reg <= action;
            key_reg <= key_wide[KEY_BITS-1:0];
            now_reg <= current_time;
        end
    end

    assign out_valid       = out_valid_reg;
    assign unexpired_count = count_out_reg;
    assign status          = status_reg;

    // The table is written only by the clearing pass or by a final decision,
    // never while a scan is reading it.
    a_write_outside_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_DECIDE))
        else $error("table written during a scan");

    // A new result never overwrites one that is still waiting.
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten");

    // An accepted transaction always starts a scan from entry zero.
    a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_SCAN && idx_reg == '0))
        else $error("scan did not start at entry zero");

    // The live count can never exceed the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(scan_cnt) <= 32'(ENTRIES))
        else $error("unexpired count exceeds table size");

endmodule

`default_nettype wire
